FILE: src/dnsw_pkg.sv
// Shared types and constants for the dotted-name to DNS wire-format converter.
// Used by the label cells and by the top level; depends on nothing else.
`default_nettype none

package dnsw_pkg;

    // Opcodes of an input word.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_LABEL_LONG = 2'd1;
    localparam logic [1:0] ST_NAME_LONG  = 2'd2;

    // Escape tracking codes.
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_SLASH = 2'd1;
    localparam logic [1:0] ESC_OCT1  = 2'd2;
    localparam logic [1:0] ESC_OCT2  = 2'd3;

    // Special characters.
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;

    // Width of a label position; labels never exceed 63 bytes.
    localparam int IDX_W = 6;

    // One input word.
    typedef struct packed {
        logic       opcode;
        logic [7:0] char_byte;
    } t_in_word;

    // One output word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       zero_follows;
        logic       is_last;
        logic [1:0] status;
    } t_out_word;

    // Control broadcast to every label cell: two write ports and a shift.
    typedef struct packed {
        logic             shift;
        logic             wa_en;
        logic [IDX_W-1:0] wa_idx;
        logic [7:0]       wa_data;
        logic             wb_en;
        logic [IDX_W-1:0] wb_idx;
        logic [7:0]       wb_data;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: src/dnsw_cell.sv
// One byte cell of the label chain: written by position, shifts toward cell 0.
// Depends on dnsw_pkg for the control struct.
`default_nettype none

module dnsw_cell
    import dnsw_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic [7:0] i_next,
    output logic [7:0]     o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Shift takes the neighbor's byte; otherwise a matching write port loads.
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift) begin
            n_byte = i_next;
        end else if (i_ctl.wb_en && i_ctl.wb_idx == IDX_W'(IDX)) begin
            n_byte = i_ctl.wb_data;
        end else if (i_ctl.wa_en && i_ctl.wa_idx == IDX_W'(IDX)) begin
            n_byte = i_ctl.wa_data;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

FILE: src/dnsw_top.sv
// Top level: dotted-name parser, label cell chain and output word register.
// Depends on dnsw_pkg and dnsw_cell.
`default_nettype none
// A result is registered and appears at the output in the cycle after its input word is accepted.
// Throughput: one input word per cycle while the output is not stalled, except that a label
// flush of n bytes occupies the output with the length byte, then one cell shift per byte,
// and input is held off until the last label byte has left the cell chain.
// Reset clears all counters, escape state and the error hold; label cells are not reset.

module dns_name_dotted_to_wire_top
    import dnsw_pkg::*;
#(
    parameter int LABEL_MAX = 63,
    parameter int NAME_MAX  = 255
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    localparam int SUM_W = 10;

    // Control state.
    logic [IDX_W-1:0] r_count, n_count;
    logic [7:0]       r_len, n_len;
    logic [1:0]       r_esc, n_esc;
    logic [7:0]       r_oct, n_oct;
    logic             r_hold, n_hold;
    logic [IDX_W:0]   r_rem;
    logic             r_end_flush;
    logic             r_ovalid;
    t_out_word        r_oword;

    // Decode of the accepted word.
    logic             w_acc;
    logic             w_out_free;
    logic             w_emit;
    logic             w_pend;
    logic             w_is_oct;
    logic [7:0]       w_oct_next;
    logic             w_room_a;
    logic [IDX_W:0]   w_base;
    logic [SUM_W-1:0] w_need;
    logic             w_norm;
    logic             w_fail;
    logic [1:0]       w_fail_st;
    logic             w_res_en;
    t_out_word        w_res_word;
    logic             w_flush_en;
    logic             w_flush_end;
    logic             w_wa_en, w_wb_en;
    logic [IDX_W-1:0] w_wa_idx, w_wb_idx;
    logic [7:0]       w_wa_data, w_wb_data;
    t_cell_ctl        w_ctl;
    logic [7:0]       w_cell_q [LABEL_MAX];

    // Handshake: input waits while a label drains or the output slot is full and stalled.
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_rem != '0) || !w_out_free;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_emit     = (r_rem != '0) && w_out_free;

    assign w_pend     = (r_esc == ESC_OCT1) || (r_esc == ESC_OCT2);
    assign w_is_oct   = (i_in_word.char_byte >= CH_ZERO) && (i_in_word.char_byte <= CH_SEVEN);
    assign w_oct_next = {r_oct[4:0], i_in_word.char_byte[2:0]};
    assign w_room_a   = (IDX_W + 1)'(r_count) < (IDX_W + 1)'(LABEL_MAX);

    // Parser: next state, cell writes and the single-word result of one input word.
    always_comb begin
        n_count     = r_count;
        n_len       = r_len;
        n_esc       = r_esc;
        n_oct       = r_oct;
        n_hold      = r_hold;
        w_base      = (IDX_W + 1)'(r_count);
        w_need      = '0;
        w_norm      = 1'b0;
        w_fail      = 1'b0;
        w_fail_st   = ST_OK;
        w_res_en    = 1'b0;
        w_res_word  = '0;
        w_flush_en  = 1'b0;
        w_flush_end = 1'b0;
        w_wa_en     = 1'b0;
        w_wa_idx    = r_count;
        w_wa_data   = r_oct;
        w_wb_en     = 1'b0;
        w_wb_idx    = r_count;
        w_wb_data   = i_in_word.char_byte;

        if (r_hold) begin
            // Discard everything up to and including the next end word.
            if (i_in_word.opcode == OP_END) begin
                n_hold  = 1'b0;
                n_count = '0;
                n_len   = '0;
                n_esc   = ESC_NONE;
                n_oct   = '0;
            end
        end else if (i_in_word.opcode == OP_END) begin
            // End of name: close out any octal byte, then flush, emit the root or report an error.
            n_count  = '0;
            n_len    = '0;
            n_esc    = ESC_NONE;
            n_oct    = '0;
            w_res_en = 1'b1;
            if (w_pend && !w_room_a) begin
                w_res_word = '{out_byte: 8'd0, zero_follows: 1'b0, is_last: 1'b1,
                               status: ST_LABEL_LONG};
            end else begin
                if (w_pend) begin
                    w_wa_en = 1'b1;
                    w_base  = (IDX_W + 1)'(r_count) + 1'b1;
                end
                w_need = SUM_W'(r_len)
                       + ((w_base != '0) ? (SUM_W'(w_base) + 1'b1) : '0);
                if (w_need + 1'b1 > SUM_W'(NAME_MAX)) begin
                    w_res_word = '{out_byte: 8'd0, zero_follows: 1'b0, is_last: 1'b1,
                                   status: ST_NAME_LONG};
                end else if (w_base != '0) begin
                    w_res_en    = 1'b0;
                    w_flush_en  = 1'b1;
                    w_flush_end = 1'b1;
                end else begin
                    w_res_word = '{out_byte: 8'd0, zero_follows: 1'b0, is_last: 1'b1,
                                   status: ST_OK};
                end
            end
        end else begin
            // Character word: escape handling first.
            unique case (r_esc)
                ESC_SLASH: begin
                    if (w_is_oct) begin
                        n_oct = {5'd0, i_in_word.char_byte[2:0]};
                        n_esc = ESC_OCT1;
                    end else begin
                        n_esc = ESC_NONE;
                        if (w_room_a) begin
                            w_wb_en = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            w_fail    = 1'b1;
                            w_fail_st = ST_LABEL_LONG;
                        end
                    end
                end
                ESC_OCT1, ESC_OCT2: begin
                    if (w_is_oct) begin
                        n_oct = w_oct_next;
                        if (r_esc == ESC_OCT1) begin
                            n_esc = ESC_OCT2;
                        end else begin
                            n_esc = ESC_NONE;
                            if (w_room_a) begin
                                w_wa_en   = 1'b1;
                                w_wa_data = w_oct_next;
                                n_count   = r_count + 1'b1;
                            end else begin
                                w_fail    = 1'b1;
                                w_fail_st = ST_LABEL_LONG;
                            end
                        end
                    end else begin
                        // Pending octal byte goes in, then the character as usual.
                        n_esc = ESC_NONE;
                        if (w_room_a) begin
                            w_wa_en = 1'b1;
                            w_base  = (IDX_W + 1)'(r_count) + 1'b1;
                            w_norm  = 1'b1;
                        end else begin
                            w_fail    = 1'b1;
                            w_fail_st = ST_LABEL_LONG;
                        end
                    end
                end
                ESC_NONE: begin
                    w_norm = 1'b1;
                end
            endcase

            // Plain character handling on the label of length w_base.
            if (w_norm) begin
                priority if (i_in_word.char_byte == CH_DOT) begin
                    n_count = w_base[IDX_W-1:0];
                    if (w_base != '0) begin
                        w_need = SUM_W'(r_len) + SUM_W'(w_base) + 1'b1;
                        if (w_need > SUM_W'(NAME_MAX)) begin
                            w_fail    = 1'b1;
                            w_fail_st = ST_NAME_LONG;
                        end else begin
                            w_flush_en = 1'b1;
                            n_len      = w_need[7:0];
                            n_count    = '0;
                        end
                    end
                end else if (i_in_word.char_byte == CH_BSLASH) begin
                    n_esc   = ESC_SLASH;
                    n_count = w_base[IDX_W-1:0];
                end else begin
                    if (w_base < (IDX_W + 1)'(LABEL_MAX)) begin
                        w_wb_en  = 1'b1;
                        w_wb_idx = w_base[IDX_W-1:0];
                        n_count  = w_base[IDX_W-1:0] + 1'b1;
                    end else begin
                        w_fail    = 1'b1;
                        w_fail_st = ST_LABEL_LONG;
                    end
                end
            end

            // An error on a character word clears the name and holds until the end word.
            if (w_fail) begin
                n_count    = '0;
                n_len      = '0;
                n_esc      = ESC_NONE;
                n_oct      = '0;
                n_hold     = 1'b1;
                w_wa_en    = 1'b0;
                w_wb_en    = 1'b0;
                w_flush_en = 1'b0;
                w_res_en   = 1'b1;
                w_res_word = '{out_byte: 8'd0, zero_follows: 1'b0, is_last: 1'b1,
                               status: w_fail_st};
            end
        end
    end

    // Cell control, gated by acceptance; shifting only happens while draining.
    always_comb begin
        w_ctl.shift   = w_emit;
        w_ctl.wa_en   = w_acc && w_wa_en;
        w_ctl.wa_idx  = w_wa_idx;
        w_ctl.wa_data = w_wa_data;
        w_ctl.wb_en   = w_acc && w_wb_en;
        w_ctl.wb_idx  = w_wb_idx;
        w_ctl.wb_data = w_wb_data;
    end

    // Label cell chain; cell 0 feeds the output.
    for (genvar gi = 0; gi < LABEL_MAX; gi++) begin : g_cell
        if (gi < LABEL_MAX - 1) begin : g_mid
            dnsw_cell #(.IDX(gi)) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_next (w_cell_q[gi + 1]),
                .o_byte (w_cell_q[gi])
            );
        end else begin : g_tail
            dnsw_cell #(.IDX(gi)) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_next (w_cell_q[gi]),
                .o_byte (w_cell_q[gi])
            );
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
            r_esc   <= ESC_NONE;
            r_oct   <= '0;
            r_hold  <= 1'b0;
        end else if (w_acc) begin
            r_count <= n_count;
            r_len   <= n_len;
            r_esc   <= n_esc;
            r_oct   <= n_oct;
            r_hold  <= n_hold;
        end
    end

    // Drain counter: bytes of the flushed label still in the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_end_flush <= 1'b0;
        end else if (w_acc && w_flush_en) begin
            r_rem       <= w_base;
            r_end_flush <= w_flush_end;
        end else if (w_emit) begin
            r_rem <= r_rem - 1'b1;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_acc && (w_res_en || w_flush_en)) begin
            r_ovalid <= 1'b1;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_flush_en) begin
            r_oword <= '{out_byte: 8'(w_base), zero_follows: 1'b0, is_last: 1'b0,
                         status: ST_OK};
        end else if (w_acc && w_res_en) begin
            r_oword <= w_res_word;
        end else if (w_emit) begin
            r_oword <= '{out_byte: w_cell_q[0],
                         zero_follows: (r_rem == (IDX_W + 1)'(1)) && r_end_flush,
                         is_last: (r_rem == (IDX_W + 1)'(1)), status: ST_OK};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    // Input must be held off while a label drains from the chain.
    a_drain_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != '0) |-> o_in_stall)
        else $error("input accepted while label drains");

    // An error result is always the last word of its item.
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != ST_OK) |-> o_out_word.is_last)
        else $error("error word not marked last");

    // The root-byte marker only appears on a final word.
    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.zero_follows) |-> o_out_word.is_last)
        else $error("zero_follows without is_last");

    // While discarding after an error, no label is pending.
    a_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold |-> (r_count == '0 && r_rem == '0))
        else $error("label state not cleared under error hold");

    // The label count never exceeds the label limit.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (IDX_W + 1)'(r_count) <= (IDX_W + 1)'(LABEL_MAX))
        else $error("label count out of range");

endmodule

`default_nettype wire

FILE: verif/tb_dns_name_dotted_to_wire_top.sv
// Self-checking testbench for the dotted-name to DNS wire-format converter.
// Needs dnsw_pkg and dns_name_dotted_to_wire_top; expected words come from a predictor kept here.
`timescale 1ns / 100ps

module tb_dns_name_dotted_to_wire_top;
    import dnsw_pkg::*;

    localparam int LABEL_MAX    = 63;
    localparam int NAME_MAX     = 255;
    localparam int RANDOM_WORDS = 100;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_LIMIT   = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // Words waiting to be sent, and wire bytes the block still owes us.
    t_in_word  pending_words[$];
    t_out_word wire_due[$];
    int        words_total = 0;
    int        words_sent = 0;
    int        mismatch_count = 0;
    int        idle_cycles = 0;

    // Driver and monitor pacing state.
    int        in_gap = 0;
    bit        in_quiet = 1'b0;
    int        out_hold = 0;
    bit        out_quiet = 1'b0;

    // Predictor copy of the converter state.
    logic [7:0] lbl_bytes[LABEL_MAX];
    int         lbl_len = 0;
    int         name_len = 0;
    logic [1:0] esc_state = ESC_NONE;
    logic [7:0] oct_val = 8'h00;
    bit         in_error = 1'b0;

    dns_name_dotted_to_wire_top #(
        .LABEL_MAX(LABEL_MAX),
        .NAME_MAX (NAME_MAX)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void log_failure(string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $time, what);
    endfunction

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic void emit(logic [7:0] b, bit zf, bit last, logic [1:0] st);
        t_out_word w;
        w.out_byte     = b;
        w.zero_follows = zf;
        w.is_last      = last;
        w.status       = st;
        wire_due.push_back(w);
    endfunction

    function automatic void clear_name();
        lbl_len   = 0;
        name_len  = 0;
        esc_state = ESC_NONE;
        oct_val   = 8'h00;
    endfunction

    // An error on a character word holds until the next end word.
    function automatic void raise_error(logic [1:0] st, bit at_end);
        clear_name();
        in_error = !at_end;
        emit(8'h00, 1'b0, 1'b1, st);
    endfunction

    function automatic bit add_byte(logic [7:0] b);
        if (lbl_len >= LABEL_MAX) return 1'b0;
        lbl_bytes[lbl_len] = b;
        lbl_len++;
        return 1'b1;
    endfunction

    // Length byte, then the label bytes; the last one closes the word.
    function automatic void flush_label(bit at_end);
        emit(8'(lbl_len), 1'b0, 1'b0, ST_OK);
        for (int i = 0; i < lbl_len; i++)
            emit(lbl_bytes[i], at_end && (i == lbl_len - 1), i == lbl_len - 1, ST_OK);
        name_len = name_len + lbl_len + 1;
        lbl_len  = 0;
    endfunction

    function automatic bit is_oct(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_SEVEN;
    endfunction

    function automatic void encode_item(t_in_word w);
        logic [7:0] c;
        int         need;
        c = w.char_byte;

        // After an error everything is dropped through the next end word.
        if (in_error) begin
            if (w.opcode == OP_END) begin
                clear_name();
                in_error = 1'b0;
            end
            return;
        end

        // End of name: settle a pending octal byte, check length, flush.
        if (w.opcode == OP_END) begin
            if (esc_state >= ESC_OCT1 && !add_byte(oct_val)) begin
                raise_error(ST_LABEL_LONG, 1'b1);
                return;
            end
            need = name_len + ((lbl_len != 0) ? lbl_len + 1 : 0);
            if (need + 1 > NAME_MAX) begin
                raise_error(ST_NAME_LONG, 1'b1);
                return;
            end
            if (lbl_len != 0) begin
                flush_label(1'b1);
            end else begin
                emit(8'h00, 1'b0, 1'b1, ST_OK);
            end
            clear_name();
            return;
        end

        // Character right after a backslash.
        if (esc_state == ESC_SLASH) begin
            if (is_oct(c)) begin
                oct_val   = c - CH_ZERO;
                esc_state = ESC_OCT1;
                return;
            end
            esc_state = ESC_NONE;
            if (!add_byte(c)) raise_error(ST_LABEL_LONG, 1'b0);
            return;
        end

        // Octal digits in progress; a non-digit appends the value and goes on.
        if (esc_state != ESC_NONE) begin
            if (is_oct(c)) begin
                oct_val = {oct_val[4:0], 3'b000} + (c - CH_ZERO);
                if (esc_state == ESC_OCT1) begin
                    esc_state = ESC_OCT2;
                    return;
                end
                esc_state = ESC_NONE;
                if (!add_byte(oct_val)) raise_error(ST_LABEL_LONG, 1'b0);
                return;
            end
            esc_state = ESC_NONE;
            if (!add_byte(oct_val)) begin
                raise_error(ST_LABEL_LONG, 1'b0);
                return;
            end
        end

        if (c == CH_DOT) begin
            if (lbl_len == 0) return;
            if (name_len + lbl_len + 1 > NAME_MAX) begin
                raise_error(ST_NAME_LONG, 1'b0);
                return;
            end
            flush_label(1'b0);
            return;
        end
        if (c == CH_BSLASH) begin
            esc_state = ESC_SLASH;
            return;
        end
        if (!add_byte(c)) raise_error(ST_LABEL_LONG, 1'b0);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------

    function automatic void push_word(logic op, logic [7:0] c);
        t_in_word w;
        w.opcode    = op;
        w.char_byte = c;
        pending_words.push_back(w);
    endfunction

    function automatic void push_char(logic [7:0] c);
        push_word(OP_CHAR, c);
    endfunction

    // The character of an end word is ignored, so it carries random bits.
    function automatic void push_end();
        push_word(OP_END, 8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_DOT || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] octal_char();
        return CH_ZERO + 8'($urandom_range(0, 7));
    endfunction

    // Characters weighted toward dots, backslashes and digits.
    function automatic logic [7:0] rough_char();
        case ($urandom_range(0, 3))
            0: return CH_DOT;
            1: return CH_BSLASH;
            2: return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One label of len bytes in mixed encodings. With exact set every byte
    // is self-contained; otherwise short octal escapes may absorb a digit
    // that follows, so the byte count is only approximate.
    function automatic void push_label(int len, bit with_dot, bit exact);
        int         r;
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                push_char(plain_char());
            end else if (r < 88) begin
                case ($urandom_range(0, 4))
                    0: c = CH_DOT;
                    1: c = CH_BSLASH;
                    default: do c = plain_char(); while (is_oct(c));
                endcase
                push_char(CH_BSLASH);
                push_char(c);
            end else if (r < 96 || exact) begin
                push_char(CH_BSLASH);
                repeat (3) push_char(octal_char());
            end else begin
                push_char(CH_BSLASH);
                repeat ($urandom_range(1, 2)) push_char(octal_char());
            end
        end
        if (with_dot) push_char(CH_DOT);
    endfunction

    // A label of plain characters, one word per byte.
    function automatic void push_plain_label(int len, bit with_dot);
        for (int i = 0; i < len; i++) push_char(plain_char());
        if (with_dot) push_char(CH_DOT);
    endfunction

    // ---------------------------------------------------------------
    // Driver: presents queued words, predicts each one it gets accepted.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        bit keep;
        if (i_rst_n) begin
            keep = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                encode_item(i_in_word);
                words_sent++;
                keep = 1'b0;
            end
            if (!keep) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_words.size() != 0) begin
                    i_in_word <= pending_words.pop_front();
                    keep = 1'b1;
                    in_gap = in_quiet ? 0 : pick_gap();
                    if ($urandom_range(0, 49) == 0) in_quiet = !in_quiet;
                end
            end
            i_in_valid <= keep;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure and in-order compare of each word.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch_words
        t_out_word due;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (wire_due.size() == 0) begin
                    log_failure($sformatf("unexpected word: byte %02h zf %0b last %0b status %0d",
                        o_out_word.out_byte, o_out_word.zero_follows, o_out_word.is_last,
                        o_out_word.status));
                end else begin
                    due = wire_due.pop_front();
                    if (o_out_word.out_byte !== due.out_byte ||
                        o_out_word.zero_follows !== due.zero_follows ||
                        o_out_word.is_last !== due.is_last ||
                        o_out_word.status !== due.status) begin
                        log_failure($sformatf({"word mismatch: expected byte %02h zf %0b ",
                            "last %0b status %0d, got byte %02h zf %0b last %0b status %0d"},
                            due.out_byte, due.zero_follows, due.is_last, due.status,
                            o_out_word.out_byte, o_out_word.zero_follows, o_out_word.is_last,
                            o_out_word.status));
                    end
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!out_quiet && $urandom_range(0, 3) == 0) out_hold = pick_gap();
                if ($urandom_range(0, 199) == 0) out_quiet = !out_quiet;
            end
        end
    end

    // Watchdog on cycles where neither side moves a word.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin : run_test
        int base;
        int kind;
        int labels;

        // Empty name: only the root byte comes back.
        push_end();
        // Leading and repeated dots around a label holding the byte extremes.
        push_char(CH_DOT);
        push_char(CH_DOT);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(CH_DOT);
        push_char(CH_DOT);
        push_end();
        // Escaped dot and escaped backslash become label bytes.
        push_char(CH_BSLASH);
        push_char(CH_DOT);
        push_char(CH_BSLASH);
        push_char(CH_BSLASH);
        // Three octal digits that wrap to zero.
        push_char(CH_BSLASH);
        push_char(CH_ZERO + 8'd4);
        push_char(CH_ZERO);
        push_char(CH_ZERO);
        // A single octal digit cut short by a dot.
        push_char(CH_BSLASH);
        push_char(CH_SEVEN);
        push_char(CH_DOT);
        // Two octal digits still pending at the end of the name.
        push_char(CH_BSLASH);
        push_char(CH_ZERO + 8'd1);
        push_char(CH_ZERO + 8'd2);
        push_end();
        // Lone backslash at the end is dropped.
        push_char(8'h61);
        push_char(CH_BSLASH);
        push_end();

        // Name length limit: three full labels take the name to 192 bytes,
        // and a 62-byte last label leaves no room for the root byte.
        repeat (3) push_plain_label(LABEL_MAX, 1'b1);
        push_plain_label(62, 1'b0);
        push_end();

        // Full label, then a pending octal byte that no longer fits at the end.
        push_plain_label(LABEL_MAX, 1'b0);
        push_char(CH_BSLASH);
        push_char(CH_ZERO + 8'd1);
        push_end();

        // Random names, mostly well formed, some broken, some noise.
        base = pending_words.size();
        while (pending_words.size() - base < RANDOM_WORDS) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                labels = $urandom_range(1, 4);
                for (int i = 0; i < labels; i++)
                    push_label(($urandom_range(0, 19) == 0) ? $urandom_range(9, LABEL_MAX)
                                                            : $urandom_range(1, 8),
                               (i < labels - 1) || ($urandom_range(0, 1) == 1), 1'b0);
                push_end();
            end else if (kind < 61) begin
                push_label($urandom_range(LABEL_MAX + 1, LABEL_MAX + 3),
                           $urandom_range(0, 1) == 1, 1'b0);
                push_end();
            end else if (kind < 75) begin
                repeat ($urandom_range(1, 6)) push_char(rough_char());
                push_end();
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 8))
                    push_word(($urandom_range(0, 9) == 0) ? OP_END : OP_CHAR, rough_char());
            end else begin
                push_label($urandom_range(0, 3), 1'b0, 1'b0);
                push_char(CH_BSLASH);
                repeat ($urandom_range(0, 3)) push_char(octal_char());
                push_end();
            end
        end
        words_total = pending_words.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Everything sent, every expected word seen, then a short drain.
        while (words_sent != words_total) @(posedge i_clk);
        while (wire_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/dnsw_pkg.sv
src/dnsw_cell.sv
src/dnsw_top.sv
verif/tb_dns_name_dotted_to_wire_top.sv
